@@ rtl/bag_array_with_iterator_top_assert.svh @@
// Assertion macros for the bag array block.
// They use clk_i and rst_ni of the module that includes this file.
`ifndef BAG_ARRAY_WITH_ITERATOR_TOP_ASSERT_SVH
`define BAG_ARRAY_WITH_ITERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bag array assertion failed");

`define BAG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bag array sequencing assertion failed");

`else

`define BAG_ASSERT(lbl, prop)
`define BAG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/bagarr_pkg.sv @@
`timescale 1ns / 1ps

package bagarr_pkg;

  localparam int VALUE_W     = 64;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD        = 3'd0,
    FUNC_REMOVE     = 3'd1,
    FUNC_CONTAINS   = 3'd2,
    FUNC_CUR_RESET  = 3'd3,
    FUNC_CUR_NEXT   = 3'd4,
    FUNC_CUR_REMOVE = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_ELEM   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_NEXT_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [VALUE_W-1:0]     item_value;
    logic [COUNT_OUT_W-1:0] item_count;
    logic                   more_left;
  } out_t;

endpackage

@@ rtl/bag_array_with_iterator_top.sv @@
`timescale 1ns / 1ps

// Bag of up to CAPACITY 64-bit words with a read cursor, kept in one RAM with
// a registered read port. One request at a time: the block stalls its input
// from acceptance until the result is loaded into the output register, which
// can still hold the previous result while a new request is accepted.
// Add, cursor reset and unused codes pass through S_EXEC and S_FINISH; cursor
// next adds S_NEXT_WAIT for its RAM read. Contains walks the stored entries
// one read per cycle; remove (by value or at the cursor) adds a shift pass
// that copies each later entry down one place, one read and one write per
// cycle.
// Values compare as raw bit patterns; item_count is the count modulo 128.
module bag_array_with_iterator_top #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bagarr_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bagarr_pkg::out_t  out_data_o
);

`include "bag_array_with_iterator_top_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // sequencer
  bagarr_pkg::state_e state_q, state_d;

  // request held for the whole operation
  logic [bagarr_pkg::FUNC_W-1:0]  func_q;
  logic [bagarr_pkg::VALUE_W-1:0] val_q;

  // bag state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cur_q, cur_d;

  // walk pointer: next RAM read; widx is the index of the data in flight
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] widx_q, widx_d;
  logic             rv_q, rv_d;

  // result under construction
  logic [bagarr_pkg::STATUS_W-1:0] status_q, status_d;
  logic                            found_q, found_d;
  logic [bagarr_pkg::VALUE_W-1:0]  item_q, item_d;

  // output register
  logic             out_valid_q, out_valid_d;
  bagarr_pkg::out_t out_q, out_d;

  // RAM ports
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [bagarr_pkg::VALUE_W-1:0] wr_data;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic [bagarr_pkg::VALUE_W-1:0] rd_data;

  logic [CNT_W+bagarr_pkg::COUNT_OUT_W-1:0] cnt_ext;
  logic                                     in_take;

  assign in_stall_o  = (state_q != bagarr_pkg::S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt_ext     = (CNT_W + bagarr_pkg::COUNT_OUT_W)'(cnt_q);

  bagarr_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    widx_d      = widx_q;
    rv_d        = rv_q;
    status_d    = status_q;
    found_d     = found_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = widx_q;
    wr_data     = rd_data;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[IDX_W-1:0];

    unique case (state_q)
      bagarr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          status_d = bagarr_pkg::ST_OK;
          found_d  = 1'b0;
          item_d   = '0;
          rv_d     = 1'b0;
          ptr_d    = '0;
          state_d  = bagarr_pkg::S_EXEC;
        end
      end

      bagarr_pkg::S_EXEC: begin
        state_d = bagarr_pkg::S_FINISH;
        case (func_q) inside
          bagarr_pkg::FUNC_ADD: begin
            if (cnt_q >= CAP_CNT) begin
              status_d = bagarr_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[IDX_W-1:0];
              wr_data = val_q;
              cnt_d   = cnt_q + CNT_ONE;
            end
          end
          bagarr_pkg::FUNC_REMOVE, bagarr_pkg::FUNC_CONTAINS: begin
            state_d = bagarr_pkg::S_SCAN;
          end
          bagarr_pkg::FUNC_CUR_RESET: begin
            cur_d = '0;
          end
          bagarr_pkg::FUNC_CUR_NEXT: begin
            if (cur_q < cnt_q) begin
              rd_en   = 1'b1;
              rd_addr = cur_q[IDX_W-1:0];
              state_d = bagarr_pkg::S_NEXT_WAIT;
            end else begin
              status_d = bagarr_pkg::ST_NO_ELEM;
            end
          end
          bagarr_pkg::FUNC_CUR_REMOVE: begin
            if (cur_q == '0) begin
              status_d = bagarr_pkg::ST_NO_ELEM;
            end else begin
              cur_d = cur_q - CNT_ONE;
              // entry cur-1 exists: shift starts reading at cur
              if (cur_q <= cnt_q) begin
                ptr_d   = cur_q;
                state_d = bagarr_pkg::S_SHIFT;
              end else begin
                status_d = bagarr_pkg::ST_NO_ELEM;
              end
            end
          end
          default: begin
          end
        endcase
      end

      bagarr_pkg::S_SCAN: begin
        if (rv_q && (rd_data == val_q)) begin
          found_d = 1'b1;
          rv_d    = 1'b0;
          if (func_q == bagarr_pkg::FUNC_REMOVE) begin
            ptr_d   = CNT_W'(widx_q) + CNT_ONE;
            state_d = bagarr_pkg::S_SHIFT;
          end else begin
            state_d = bagarr_pkg::S_FINISH;
          end
        end else if (ptr_q < cnt_q) begin
          rd_en  = 1'b1;
          rv_d   = 1'b1;
          widx_d = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + CNT_ONE;
        end else begin
          // last read in flight missed: drain it, then report not found
          rv_d = 1'b0;
          if (!rv_q) begin
            status_d = bagarr_pkg::ST_NOT_FOUND;
            state_d  = bagarr_pkg::S_FINISH;
          end
        end
      end

      bagarr_pkg::S_SHIFT: begin
        // write back the entry read last cycle one place down
        wr_en = rv_q;
        if (ptr_q < cnt_q) begin
          rd_en  = 1'b1;
          rv_d   = 1'b1;
          widx_d = IDX_W'(ptr_q - CNT_ONE);
          ptr_d  = ptr_q + CNT_ONE;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            cnt_d   = cnt_q - CNT_ONE;
            state_d = bagarr_pkg::S_FINISH;
          end
        end
      end

      bagarr_pkg::S_NEXT_WAIT: begin
        item_d  = rd_data;
        cur_d   = cur_q + CNT_ONE;
        state_d = bagarr_pkg::S_FINISH;
      end

      bagarr_pkg::S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.found      = found_q;
          out_d.item_value = item_q;
          out_d.item_count = cnt_ext[bagarr_pkg::COUNT_OUT_W-1:0];
          out_d.more_left  = (cur_q < cnt_q);
          state_d          = bagarr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bagarr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bagarr_pkg::S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= in_data_i.func;
      val_q  <= in_data_i.value;
    end
    ptr_q    <= ptr_d;
    widx_q   <= widx_d;
    status_q <= status_d;
    found_q  <= found_d;
    item_q   <= item_d;
    out_q    <= out_d;
  end

  // count and cursor never pass the capacity
  `BAG_ASSERT(a_cnt_range, cnt_q <= CAP_CNT)
  `BAG_ASSERT(a_cur_range, cur_q <= CAP_CNT)
  // an accepted request stalls the input once it has been taken
  `BAG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // the RAM is written only while an operation is running
  `BAG_ASSERT(a_no_write_idle, !(wr_en && (state_q == bagarr_pkg::S_IDLE)))

endmodule

@@ rtl/bagarr_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write, one registered read per cycle.
module bagarr_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [ADDR_W-1:0]                 wr_addr_i,
  input  logic [bagarr_pkg::VALUE_W-1:0]    wr_data_i,
  input  logic                              rd_en_i,
  input  logic [ADDR_W-1:0]                 rd_addr_i,
  output logic [bagarr_pkg::VALUE_W-1:0]    rd_data_o
);

  logic [bagarr_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [bagarr_pkg::VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
